FILE: design/nmtsh_pkg.sv
// Shared types, codes and constants of the NMT slave heartbeat and LED block.
package nmtsh_pkg;

    // Register file
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    localparam logic [2:0] REG_NODE_ID     = 3'd0;
    localparam logic [2:0] REG_HB_PERIOD   = 3'd1;
    localparam logic [2:0] REG_FIRST_HB    = 3'd2;
    localparam logic [2:0] REG_STARTUP_PRE = 3'd3;
    localparam logic [2:0] REG_ERR_ACTIONS = 3'd4;
    localparam logic [2:0] REG_ERR_ACT_EN  = 3'd5;

    // Item kinds
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_BLINK = 2'd2;

    // NMT command specifiers
    localparam logic [7:0] NMT_START      = 8'd1;
    localparam logic [7:0] NMT_STOP       = 8'd2;
    localparam logic [7:0] NMT_PREOP      = 8'd128;
    localparam logic [7:0] NMT_RESET_NODE = 8'd129;
    localparam logic [7:0] NMT_RESET_COMM = 8'd130;
    localparam logic [3:0] NMT_FRAME_LEN  = 4'd2;
    localparam logic [7:0] NMT_ALL_NODES  = 8'd0;

    // Operating states
    localparam logic [6:0] ST_INIT    = 7'd0;
    localparam logic [6:0] ST_STOPPED = 7'd4;
    localparam logic [6:0] ST_OPER    = 7'd5;
    localparam logic [6:0] ST_PREOP   = 7'd127;

    // Reset requests
    localparam logic [1:0] RST_NONE = 2'd0;
    localparam logic [1:0] RST_APP  = 2'd1;
    localparam logic [1:0] RST_COMM = 2'd2;

    // Error action codes
    localparam logic [1:0] ACT_PREOP = 2'd0;
    localparam logic [1:0] ACT_STOP  = 2'd2;

    // Error action slots
    localparam int ACT_SEVERE_COMM = 0;
    localparam int ACT_COMM        = 1;
    localparam int ACT_PASSIVE     = 2;
    localparam int ACT_GENERIC     = 3;
    localparam int ACT_PROFILE     = 4;
    localparam int ACT_MANUF       = 5;

    localparam logic [15:0] HB_TIMER_RESET = 16'hFFFF;

    // LED levels and pattern counter turning points
    localparam logic signed [7:0] LED_ON        = 8'sd1;
    localparam logic signed [7:0] LED_OFF       = -8'sd1;
    localparam logic signed [7:0] PAT_FLASH_END = 8'sd4;
    localparam logic signed [7:0] PAT_BLINK_LOW = -8'sd4;
    localparam logic signed [7:0] PAT_LONG_OFF  = -8'sd20;
    localparam logic signed [7:0] PAT_GAP1      = -8'sd104;
    localparam logic signed [7:0] PAT_GAP1_END  = -8'sd100;
    localparam logic signed [7:0] PAT_MARK1     = 8'sd100;
    localparam logic signed [7:0] PAT_MARK1_END = 8'sd104;
    localparam logic signed [7:0] PAT_GAP2      = -8'sd114;
    localparam logic signed [7:0] PAT_GAP2_END  = -8'sd110;
    localparam logic signed [7:0] PAT_MARK2     = 8'sd110;
    localparam logic signed [7:0] PAT_MARK2_END = 8'sd114;
    localparam logic signed [7:0] PAT_GAP3      = -8'sd124;
    localparam logic signed [7:0] PAT_GAP3_END  = -8'sd120;
    localparam logic signed [7:0] PAT_MARK3     = 8'sd120;
    localparam logic signed [7:0] PAT_MARK3_END = 8'sd124;

    typedef struct packed {
        logic [6:0]  node_id;
        logic [15:0] hb_period;
        logic [15:0] first_hb;
        logic        startup_preop;
        logic [11:0] err_actions;
        logic        err_act_en;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [3:0]  frame_length;
        logic [7:0]  frame_command;
        logic [7:0]  frame_node;
        logic [15:0] elapsed_ms;
        logic [7:0]  error_register;
        logic [6:0]  fault_flags;
        logic [15:0] next_timer_in;
    } item_t;

    typedef struct packed {
        logic signed [7:0] flicker;
        logic signed [7:0] blink;
        logic signed [7:0] single_flash;
        logic signed [7:0] double_flash;
        logic signed [7:0] triple_flash;
        logic signed [7:0] quad_flash;
    } led_ctr_t;

    typedef struct packed {
        logic [6:0]        state_code;
        logic              state_changed;
        logic [1:0]        reset_request;
        logic              heartbeat_send;
        logic [6:0]        heartbeat_byte;
        logic [15:0]       next_timer_out;
        logic signed [7:0] green_led_level;
        logic signed [7:0] red_led_level;
    } res_t;

endpackage

FILE: design/nmtsh_cfg.sv
// APB register file holding the node configuration.
module nmtsh_cfg
    import nmtsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write registers on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_id       <= 7'd1;
            cfg_reg.hb_period     <= '0;
            cfg_reg.first_hb      <= '0;
            cfg_reg.startup_preop <= 1'b0;
            cfg_reg.err_actions   <= '0;
            cfg_reg.err_act_en    <= 1'b1;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NODE_ID:     cfg_reg.node_id       <= pwdata[6:0];
                REG_HB_PERIOD:   cfg_reg.hb_period     <= pwdata[15:0];
                REG_FIRST_HB:    cfg_reg.first_hb      <= pwdata[15:0];
                REG_STARTUP_PRE: cfg_reg.startup_preop <= pwdata[0];
                REG_ERR_ACTIONS: cfg_reg.err_actions   <= pwdata[11:0];
                REG_ERR_ACT_EN:  cfg_reg.err_act_en    <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            REG_NODE_ID:     prdata = {25'd0, cfg_reg.node_id};
            REG_HB_PERIOD:   prdata = {16'd0, cfg_reg.hb_period};
            REG_FIRST_HB:    prdata = {16'd0, cfg_reg.first_hb};
            REG_STARTUP_PRE: prdata = {31'd0, cfg_reg.startup_preop};
            REG_ERR_ACTIONS: prdata = {20'd0, cfg_reg.err_actions};
            REG_ERR_ACT_EN:  prdata = {31'd0, cfg_reg.err_act_en};
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: design/nmtsh_blink.sv
// Six LED pattern counters stepped by the 50 ms blink tick.
module nmtsh_blink
    import nmtsh_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    output led_ctr_t ctr
);

    led_ctr_t ctr_reg;
    led_ctr_t ctr_next;
    led_ctr_t inc;

    assign ctr = ctr_reg;

    // Advance each pattern and fold it back at its turning points
    always_comb begin
        inc.flicker      = ctr_reg.flicker + 8'sd1;
        inc.blink        = ctr_reg.blink + 8'sd1;
        inc.single_flash = ctr_reg.single_flash + 8'sd1;
        inc.double_flash = ctr_reg.double_flash + 8'sd1;
        inc.triple_flash = ctr_reg.triple_flash + 8'sd1;
        inc.quad_flash   = ctr_reg.quad_flash + 8'sd1;

        ctr_next.flicker      = (inc.flicker >= LED_ON) ? LED_OFF : inc.flicker;
        ctr_next.blink        = (inc.blink >= PAT_FLASH_END) ? PAT_BLINK_LOW : inc.blink;
        ctr_next.single_flash = (inc.single_flash >= PAT_FLASH_END) ? PAT_LONG_OFF
                                                                    : inc.single_flash;

        case (inc.double_flash)
            PAT_FLASH_END: ctr_next.double_flash = PAT_GAP1;
            PAT_GAP1_END:  ctr_next.double_flash = PAT_MARK1;
            PAT_MARK1_END: ctr_next.double_flash = PAT_LONG_OFF;
            default:       ctr_next.double_flash = inc.double_flash;
        endcase

        case (inc.triple_flash)
            PAT_FLASH_END: ctr_next.triple_flash = PAT_GAP1;
            PAT_GAP1_END:  ctr_next.triple_flash = PAT_MARK1;
            PAT_MARK1_END: ctr_next.triple_flash = PAT_GAP2;
            PAT_GAP2_END:  ctr_next.triple_flash = PAT_MARK2;
            PAT_MARK2_END: ctr_next.triple_flash = PAT_LONG_OFF;
            default:       ctr_next.triple_flash = inc.triple_flash;
        endcase

        case (inc.quad_flash)
            PAT_FLASH_END: ctr_next.quad_flash = PAT_GAP1;
            PAT_GAP1_END:  ctr_next.quad_flash = PAT_MARK1;
            PAT_MARK1_END: ctr_next.quad_flash = PAT_GAP2;
            PAT_GAP2_END:  ctr_next.quad_flash = PAT_MARK2;
            PAT_MARK2_END: ctr_next.quad_flash = PAT_GAP3;
            PAT_GAP3_END:  ctr_next.quad_flash = PAT_MARK3;
            PAT_MARK3_END: ctr_next.quad_flash = PAT_LONG_OFF;
            default:       ctr_next.quad_flash = inc.quad_flash;
        endcase
    end

    // Hold counters between ticks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_reg <= '0;
        end else if (step) begin
            ctr_reg <= ctr_next;
        end
    end

endmodule

FILE: design/nmtsh_core.sv
// NMT state machine, heartbeat producer, LED levels and error actions.
module nmtsh_core
    import nmtsh_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step,
    input  item_t    item,
    input  cfg_t     cfg,
    input  led_ctr_t ctr,
    output res_t     res
);

    logic [6:0]        op_reg,    op_next;
    logic [1:0]        latch_reg, latch_next;
    logic [15:0]       timer_reg, timer_next;
    logic signed [7:0] green_reg, green_next;
    logic signed [7:0] red_reg,   red_next;

    function automatic logic [6:0] apply_act(input logic [6:0] st, input logic [1:0] act);
        logic [6:0] r;
        case (act)
            ACT_PREOP: r = ST_PREOP;
            ACT_STOP:  r = ST_STOPPED;
            default:   r = st;
        endcase
        return r;
    endfunction

    function automatic logic act_drops(input logic [1:0] act);
        return (act == ACT_PREOP) || (act == ACT_STOP);
    endfunction

    // Work out one item against the held state
    always_comb begin
        logic        addressed;
        logic        passive;
        logic        busoff;
        logic        hbfault;
        logic [15:0] sum;
        logic        due;
        logic [15:0] t1;
        logic [6:0]  st1;
        logic [15:0] diff;
        logic [15:0] nxt;
        logic [7:0]  er;
        logic [6:0]  st2;
        logic        hb_send;
        logic [6:0]  hb_byte;

        op_next    = op_reg;
        latch_next = latch_reg;
        timer_next = timer_reg;
        green_next = green_reg;
        red_next   = red_reg;
        hb_send    = 1'b0;
        hb_byte    = ST_INIT;
        nxt        = item.next_timer_in;

        addressed = (item.frame_length == NMT_FRAME_LEN) &&
                    ((item.frame_node == NMT_ALL_NODES) ||
                     (item.frame_node == {1'b0, cfg.node_id}));
        passive = item.fault_flags[0] || item.fault_flags[1];
        busoff  = item.fault_flags[2];
        hbfault = item.fault_flags[4] || item.fault_flags[5];

        // Heartbeat timer and boot-up
        sum = timer_reg + item.elapsed_ms;
        due = ((cfg.hb_period != 16'd0) && (sum >= cfg.hb_period)) || (op_reg == ST_INIT);
        t1  = sum;
        st1 = op_reg;
        if (due) begin
            t1 = 16'd0;
            if (op_reg == ST_INIT) begin
                t1  = (cfg.hb_period > cfg.first_hb) ? cfg.hb_period - cfg.first_hb : 16'd0;
                st1 = cfg.startup_preop ? ST_PREOP : ST_OPER;
            end
        end
        diff = cfg.hb_period - t1;

        // Error actions in operational
        er = item.error_register;
        if (passive && act_drops(cfg.err_actions[2*ACT_PASSIVE +: 2])) begin
            er[4] = 1'b1;
        end
        st2 = st1;
        if (er[4]) begin
            if (act_drops(cfg.err_actions[2*ACT_COMM +: 2])) begin
                st2 = apply_act(st2, cfg.err_actions[2*ACT_COMM +: 2]);
            end else if (busoff || hbfault) begin
                st2 = apply_act(st2, cfg.err_actions[2*ACT_SEVERE_COMM +: 2]);
            end
        end
        if (er[0]) st2 = apply_act(st2, cfg.err_actions[2*ACT_GENERIC +: 2]);
        if (er[5]) st2 = apply_act(st2, cfg.err_actions[2*ACT_PROFILE +: 2]);
        if (er[7]) st2 = apply_act(st2, cfg.err_actions[2*ACT_MANUF +: 2]);

        case (item.command)
            CMD_FRAME: begin
                if (addressed) begin
                    case (item.frame_command)
                        NMT_START: begin
                            if (item.error_register == 8'd0) op_next = ST_OPER;
                        end
                        NMT_STOP:       op_next    = ST_STOPPED;
                        NMT_PREOP:      op_next    = ST_PREOP;
                        NMT_RESET_NODE: latch_next = RST_APP;
                        NMT_RESET_COMM: latch_next = RST_COMM;
                        default: ;
                    endcase
                end
            end
            CMD_TICK: begin
                hb_send    = due;
                hb_byte    = due ? op_reg : ST_INIT;
                timer_next = t1;
                op_next    = st1;

                // Lower the caller's deadline
                if (cfg.hb_period != 16'd0) begin
                    if (t1 < cfg.hb_period) begin
                        if (nxt > diff) nxt = diff;
                    end else begin
                        nxt = 16'd0;
                    end
                end

                // Run LED
                if (st1 == ST_STOPPED)    green_next = ctr.single_flash;
                else if (st1 == ST_PREOP) green_next = ctr.blink;
                else if (st1 == ST_OPER)  green_next = LED_ON;

                // Error LED by fault priority
                if (busoff)                                red_next = LED_ON;
                else if (item.fault_flags[3])              red_next = ctr.triple_flash;
                else if (hbfault)                          red_next = ctr.double_flash;
                else if (passive || item.fault_flags[6])   red_next = ctr.single_flash;
                else if (item.error_register != 8'd0)
                    red_next = (ctr.blink >= 8'sd0) ? LED_OFF : LED_ON;
                else                                       red_next = LED_OFF;

                if (cfg.err_act_en && (st1 == ST_OPER) && (er != 8'd0)) begin
                    op_next = st2;
                    if (st2 != ST_OPER) timer_next = cfg.hb_period;
                end
            end
            default: ;
        endcase

        res.state_code      = op_next;
        res.state_changed   = (op_next != op_reg);
        res.reset_request   = latch_next;
        res.heartbeat_send  = hb_send;
        res.heartbeat_byte  = hb_byte;
        res.next_timer_out  = nxt;
        res.green_led_level = green_next;
        res.red_led_level   = red_next;
    end

    // Commit state when the item moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg    <= ST_INIT;
            latch_reg <= RST_NONE;
            timer_reg <= HB_TIMER_RESET;
            green_reg <= LED_OFF;
            red_reg   <= LED_ON;
        end else if (step) begin
            op_reg    <= op_next;
            latch_reg <= latch_next;
            timer_reg <= timer_next;
            green_reg <= green_next;
            red_reg   <= red_next;
        end
    end

`ifndef SYNTH
    // A latched reset request is never withdrawn
    a_latch_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (latch_reg != RST_NONE) |=> (latch_reg != RST_NONE))
        else $error("reset request latch cleared");

    // A tick in initializing sends boot-up and leaves initializing
    a_boot: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (item.command == CMD_TICK) && (op_reg == ST_INIT)) |->
        (res.heartbeat_send && (res.heartbeat_byte == ST_INIT) &&
         (op_next != ST_INIT)))
        else $error("boot-up not produced on first tick");

    // Only process ticks move the heartbeat timer
    a_timer_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && (item.command != CMD_TICK)) |=> $stable(timer_reg))
        else $error("heartbeat timer moved on a non-tick item");
`endif

endmodule

FILE: design/nmt_slave_state_heartbeat_led.sv
// Top level of the NMT slave state, heartbeat producer and status LED block.
// An accepted input beat is held in the input register, and its result then in the result register.
// Throughput: one item per cycle while m_ready stays high; a stalled result
// holds the input register once it is full, so s_ready drops only then.
// Reset: synchronous active-low aresetn; state initializing, no reset request,
// heartbeat timer all ones, pattern counters zero, run LED off, error LED on.
module nmt_slave_state_heartbeat_led
    import nmtsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input items
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_command,
    input  logic [3:0]        s_frame_length,
    input  logic [7:0]        s_frame_command,
    input  logic [7:0]        s_frame_node,
    input  logic [15:0]       s_elapsed_ms,
    input  logic [7:0]        s_error_register,
    input  logic [6:0]        s_fault_flags,
    input  logic [15:0]       s_next_timer_in,
    // results
    output logic              m_valid,
    input  logic              m_ready,
    output logic [6:0]        m_state_code,
    output logic              m_state_changed,
    output logic [1:0]        m_reset_request,
    output logic              m_heartbeat_send,
    output logic [6:0]        m_heartbeat_byte,
    output logic [15:0]       m_next_timer_out,
    output logic signed [7:0] m_green_led_level,
    output logic signed [7:0] m_red_led_level
);

    cfg_t     cfg;
    led_ctr_t ctr;
    item_t    item_reg;
    res_t     res;
    res_t     res_reg;
    logic     in_valid_reg,  in_valid_next;
    logic     out_valid_reg, out_valid_next;
    logic     s_beat;
    logic     fire;

    nmtsh_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nmtsh_blink u_blink (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire && (item_reg.command == CMD_BLINK)),
        .ctr     (ctr)
    );

    nmtsh_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .ctr     (ctr),
        .res     (res)
    );

    // Handshake and pipeline advance
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign s_beat  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_beat ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        out_valid_next = fire ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);
    end

    // Control flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture input beat and result
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            item_reg.command        <= s_command;
            item_reg.frame_length   <= s_frame_length;
            item_reg.frame_command  <= s_frame_command;
            item_reg.frame_node     <= s_frame_node;
            item_reg.elapsed_ms     <= s_elapsed_ms;
            item_reg.error_register <= s_error_register;
            item_reg.fault_flags    <= s_fault_flags;
            item_reg.next_timer_in  <= s_next_timer_in;
        end
        if (fire) begin
            res_reg <= res;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_state_code      = res_reg.state_code;
    assign m_state_changed   = res_reg.state_changed;
    assign m_reset_request   = res_reg.reset_request;
    assign m_heartbeat_send  = res_reg.heartbeat_send;
    assign m_heartbeat_byte  = res_reg.heartbeat_byte;
    assign m_next_timer_out  = res_reg.next_timer_out;
    assign m_green_led_level = res_reg.green_led_level;
    assign m_red_led_level   = res_reg.red_led_level;

`ifndef SYNTH
    // Input stalls only when both stages are full and the output is stalled
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // A processed item always shows up as a result beat
    a_fire_out: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> out_valid_reg)
        else $error("processed item not presented");

    // A held item is not dropped before it is processed
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !fire) |=> in_valid_reg)
        else $error("pending item dropped");
`endif

endmodule

FILE: dv/nmtsh_checker.sv
// Result checker for the NMT slave block: tracks node state, predicts each result beat, compares.
`timescale 1ns / 100ps

module nmtsh_checker
    import nmtsh_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              s_valid,
    input  logic              s_ready,
    input  item_t             s_item,
    input  logic              m_valid,
    input  logic              m_ready,
    input  res_t              m_res,
    output int                mismatch_count,
    output int                results_due
);

    // Shadow registers and node state
    cfg_t              cfg;
    logic [6:0]        op_state;
    logic [1:0]        rst_latch;
    logic [15:0]       hb_timer;
    logic signed [7:0] flicker_ctr;
    logic signed [7:0] blink_ctr;
    logic signed [7:0] single_ctr;
    logic signed [7:0] double_ctr;
    logic signed [7:0] triple_ctr;
    logic signed [7:0] quad_ctr;
    logic signed [7:0] run_lvl;
    logic signed [7:0] err_lvl;

    res_t due_beats[$];
    int   n_bad;

    string field_tag [8] = '{"state_code", "state_changed", "reset_request", "heartbeat_send",
                             "heartbeat_byte", "next_timer_out", "green_led_level",
                             "red_led_level"};

    function automatic logic [1:0] act_code(input int k);
        return cfg.err_actions[2*k +: 2];
    endfunction

    // An action of preop or stop leaves operational; the others keep the state
    function automatic logic drops(input int k);
        return act_code(k) == ACT_PREOP || act_code(k) == ACT_STOP;
    endfunction

    function automatic logic [6:0] take_action(input logic [6:0] st, input int k);
        if (act_code(k) == ACT_PREOP) return ST_PREOP;
        if (act_code(k) == ACT_STOP) return ST_STOPPED;
        return st;
    endfunction

    function automatic logic [15:0] field_of(input res_t r, input int i);
        case (i)
            0: return 16'(r.state_code);
            1: return 16'(r.state_changed);
            2: return 16'(r.reset_request);
            3: return 16'(r.heartbeat_send);
            4: return 16'(r.heartbeat_byte);
            5: return r.next_timer_out;
            6: return 16'(r.green_led_level);
            default: return 16'(r.red_led_level);
        endcase
    endfunction

    // Advance the six LED pattern counters by one 50 ms step
    task automatic step_patterns();
        flicker_ctr = flicker_ctr + 8'sd1;
        if (flicker_ctr >= LED_ON) flicker_ctr = LED_OFF;
        blink_ctr = blink_ctr + 8'sd1;
        if (blink_ctr >= PAT_FLASH_END) blink_ctr = PAT_BLINK_LOW;
        single_ctr = single_ctr + 8'sd1;
        if (single_ctr >= PAT_FLASH_END) single_ctr = PAT_LONG_OFF;

        double_ctr = double_ctr + 8'sd1;
        case (double_ctr)
            PAT_FLASH_END: double_ctr = PAT_GAP1;
            PAT_GAP1_END:  double_ctr = PAT_MARK1;
            PAT_MARK1_END: double_ctr = PAT_LONG_OFF;
            default: ;
        endcase

        triple_ctr = triple_ctr + 8'sd1;
        case (triple_ctr)
            PAT_FLASH_END: triple_ctr = PAT_GAP1;
            PAT_GAP1_END:  triple_ctr = PAT_MARK1;
            PAT_MARK1_END: triple_ctr = PAT_GAP2;
            PAT_GAP2_END:  triple_ctr = PAT_MARK2;
            PAT_MARK2_END: triple_ctr = PAT_LONG_OFF;
            default: ;
        endcase

        quad_ctr = quad_ctr + 8'sd1;
        case (quad_ctr)
            PAT_FLASH_END: quad_ctr = PAT_GAP1;
            PAT_GAP1_END:  quad_ctr = PAT_MARK1;
            PAT_MARK1_END: quad_ctr = PAT_GAP2;
            PAT_GAP2_END:  quad_ctr = PAT_MARK2;
            PAT_MARK2_END: quad_ctr = PAT_GAP3;
            PAT_GAP3_END:  quad_ctr = PAT_MARK3;
            PAT_MARK3_END: quad_ctr = PAT_LONG_OFF;
            default: ;
        endcase
    endtask

    // Apply one input beat to the node and build the result it must produce
    task automatic advance_node(input item_t it, output res_t r);
        logic [6:0]  prior;
        logic [15:0] nxt;
        logic [15:0] hb;
        logic [15:0] diff;
        logic [7:0]  er;
        logic        passive;
        logic        busoff;
        logic        hbfault;

        prior   = op_state;
        nxt     = it.next_timer_in;
        hb      = cfg.hb_period;
        passive = |it.fault_flags[1:0];
        busoff  = it.fault_flags[2];
        hbfault = |it.fault_flags[5:4];
        r       = '0;

        case (it.command)
            CMD_FRAME: begin
                if (it.frame_length == NMT_FRAME_LEN &&
                    (it.frame_node == NMT_ALL_NODES || it.frame_node == {1'b0, cfg.node_id})) begin
                    case (it.frame_command)
                        NMT_START: if (it.error_register == 8'd0) op_state = ST_OPER;
                        NMT_STOP:       op_state = ST_STOPPED;
                        NMT_PREOP:      op_state = ST_PREOP;
                        NMT_RESET_NODE: rst_latch = RST_APP;
                        NMT_RESET_COMM: rst_latch = RST_COMM;
                        default: ;
                    endcase
                end
            end
            CMD_TICK: begin
                // heartbeat timer wraps at 16 bits; boot-up goes out from initializing
                hb_timer = hb_timer + it.elapsed_ms;
                if ((hb != 16'd0 && hb_timer >= hb) || op_state == ST_INIT) begin
                    hb_timer         = '0;
                    r.heartbeat_send = 1'b1;
                    r.heartbeat_byte = op_state;
                    if (op_state == ST_INIT) begin
                        hb_timer = (hb > cfg.first_hb) ? hb - cfg.first_hb : 16'd0;
                        op_state = cfg.startup_preop ? ST_PREOP : ST_OPER;
                    end
                end
                if (hb != 16'd0) begin
                    if (hb_timer < hb) begin
                        diff = hb - hb_timer;
                        if (nxt > diff) nxt = diff;
                    end else begin
                        nxt = '0;
                    end
                end

                // run LED follows the state, error LED the most severe fault
                case (op_state)
                    ST_STOPPED: run_lvl = single_ctr;
                    ST_PREOP:   run_lvl = blink_ctr;
                    ST_OPER:    run_lvl = LED_ON;
                    default: ;
                endcase
                if (busoff) err_lvl = LED_ON;
                else if (it.fault_flags[3]) err_lvl = triple_ctr;
                else if (hbfault) err_lvl = double_ctr;
                else if (passive || it.fault_flags[6]) err_lvl = single_ctr;
                else if (it.error_register != 8'd0) err_lvl = (blink_ctr >= 8'sd0) ? LED_OFF : LED_ON;
                else err_lvl = LED_OFF;

                // error classes may force the node out of operational
                if (cfg.err_act_en && op_state == ST_OPER) begin
                    er = it.error_register;
                    if (passive && drops(ACT_PASSIVE)) er[4] = 1'b1;
                    if (er != 8'd0) begin
                        if (er[4]) begin
                            if (drops(ACT_COMM)) op_state = take_action(op_state, ACT_COMM);
                            else if (busoff || hbfault)
                                op_state = take_action(op_state, ACT_SEVERE_COMM);
                        end
                        if (er[0]) op_state = take_action(op_state, ACT_GENERIC);
                        if (er[5]) op_state = take_action(op_state, ACT_PROFILE);
                        if (er[7]) op_state = take_action(op_state, ACT_MANUF);
                        if (op_state != ST_OPER) hb_timer = hb;
                    end
                end
            end
            CMD_BLINK: step_patterns();
            default: ;
        endcase

        r.state_code      = op_state;
        r.state_changed   = (prior != op_state);
        r.reset_request   = rst_latch;
        r.next_timer_out  = nxt;
        r.green_led_level = run_lvl;
        r.red_led_level   = err_lvl;
    endtask

    task automatic compare_beat(input res_t want, input res_t got);
        for (int i = 0; i < 8; i++) begin
            if (field_of(want, i) !== field_of(got, i)) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("%0t: mismatch on %s: expected %h, got %h", $realtime,
                             field_tag[i], field_of(want, i), field_of(got, i));
            end
        end
    endtask

    // Track register writes, predict on input beats, check on result beats
    always @(posedge aclk) begin
        res_t want;
        if (!aresetn) begin
            cfg         = '0;
            cfg.node_id = 7'd1;
            cfg.err_act_en = 1'b1;
            op_state    = ST_INIT;
            rst_latch   = RST_NONE;
            hb_timer    = HB_TIMER_RESET;
            flicker_ctr = '0;
            blink_ctr   = '0;
            single_ctr  = '0;
            double_ctr  = '0;
            triple_ctr  = '0;
            quad_ctr    = '0;
            run_lvl     = LED_OFF;
            err_lvl     = LED_ON;
            n_bad       = 0;
            due_beats.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[APB_AW-1:2])
                    REG_NODE_ID:     cfg.node_id = pwdata[6:0];
                    REG_HB_PERIOD:   cfg.hb_period = pwdata[15:0];
                    REG_FIRST_HB:    cfg.first_hb = pwdata[15:0];
                    REG_STARTUP_PRE: cfg.startup_preop = pwdata[0];
                    REG_ERR_ACTIONS: cfg.err_actions = pwdata[11:0];
                    REG_ERR_ACT_EN:  cfg.err_act_en = pwdata[0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (due_beats.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("%0t: result beat with nothing expected, got %h",
                                 $realtime, m_res);
                end else begin
                    want = due_beats.pop_front();
                    compare_beat(want, m_res);
                end
            end
            if (s_valid && s_ready) begin
                advance_node(s_item, want);
                due_beats.push_back(want);
            end
        end
        mismatch_count <= n_bad;
        results_due    <= due_beats.size();
    end

endmodule

FILE: dv/tb_nmt_slave_state_heartbeat_led.sv
// Testbench top for the NMT slave block: clock, reset, register setup, stimulus and verdict.
`timescale 1ns / 100ps

module tb_nmt_slave_state_heartbeat_led;
    import nmtsh_pkg::*;

    localparam int         CYCLE_LIMIT  = 200000;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         RANDOM_ITEMS = 1850;
    localparam int         PHASES       = 8;
    localparam logic [1:0] CMD_UNUSED   = 2'd3;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [APB_AW-1:0] paddr   = '0;
    logic [APB_DW-1:0] pwdata  = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              s_valid = 1'b0;
    logic              s_ready;
    item_t             s_item  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [6:0]        m_state_code;
    logic              m_state_changed;
    logic [1:0]        m_reset_request;
    logic              m_heartbeat_send;
    logic [6:0]        m_heartbeat_byte;
    logic [15:0]       m_next_timer_out;
    logic signed [7:0] m_green_led_level;
    logic signed [7:0] m_red_led_level;

    int   mismatch_count;
    int   results_due;
    cfg_t node_cfg;
    int   burst_left = 0;
    int   stall_left = 0;
    int   stall_mode = 0;

    nmt_slave_state_heartbeat_led uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_item.command),
        .s_frame_length    (s_item.frame_length),
        .s_frame_command   (s_item.frame_command),
        .s_frame_node      (s_item.frame_node),
        .s_elapsed_ms      (s_item.elapsed_ms),
        .s_error_register  (s_item.error_register),
        .s_fault_flags     (s_item.fault_flags),
        .s_next_timer_in   (s_item.next_timer_in),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_state_code      (m_state_code),
        .m_state_changed   (m_state_changed),
        .m_reset_request   (m_reset_request),
        .m_heartbeat_send  (m_heartbeat_send),
        .m_heartbeat_byte  (m_heartbeat_byte),
        .m_next_timer_out  (m_next_timer_out),
        .m_green_led_level (m_green_led_level),
        .m_red_led_level   (m_red_led_level)
    );

    nmtsh_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_item         (s_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_res          ({m_state_code, m_state_changed, m_reset_request, m_heartbeat_send,
                          m_heartbeat_byte, m_next_timer_out, m_green_led_level,
                          m_red_led_level}),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // 4 ns clock
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Stall the result channel on a randomly chosen pattern that changes at random intervals
    always @(posedge aclk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            2: m_ready <= (stall_left % 4 == 0);
            default: m_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // Write one register; psel stays high so back-to-back writes chain
    task automatic apb_write(input logic [2:0] idx, input logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
    endtask

    task automatic load_config(input cfg_t c);
        apb_write(REG_NODE_ID, APB_DW'(c.node_id));
        apb_write(REG_HB_PERIOD, APB_DW'(c.hb_period));
        apb_write(REG_FIRST_HB, APB_DW'(c.first_hb));
        apb_write(REG_STARTUP_PRE, APB_DW'(c.startup_preop));
        apb_write(REG_ERR_ACTIONS, APB_DW'(c.err_actions));
        apb_write(REG_ERR_ACT_EN, APB_DW'(c.err_act_en));
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        node_cfg = c;
    endtask

    // Present one beat; open a new burst with a random gap when the old one runs out
    task automatic send_item(input item_t it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_item  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic item_t noise_item();
        item_t it;
        it.command        = 2'($urandom_range(0, 3));
        it.frame_length   = 4'($urandom_range(0, 8));
        it.frame_command  = 8'($urandom_range(0, 255));
        it.frame_node     = 8'($urandom_range(0, 255));
        it.elapsed_ms     = 16'($urandom_range(0, 65535));
        it.error_register = 8'($urandom_range(0, 255));
        it.fault_flags    = 7'($urandom_range(0, 127));
        it.next_timer_in  = 16'($urandom_range(0, 65535));
        return it;
    endfunction

    function automatic item_t nmt_frame(input logic [3:0] len, input logic [7:0] cs,
                                        input logic [7:0] node, input logic [7:0] ereg);
        item_t it;
        it = noise_item();
        it.command        = CMD_FRAME;
        it.frame_length   = len;
        it.frame_command  = cs;
        it.frame_node     = node;
        it.error_register = ereg;
        return it;
    endfunction

    function automatic item_t proc_tick(input logic [15:0] ms, input logic [7:0] ereg,
                                        input logic [6:0] flt, input logic [15:0] nxt);
        item_t it;
        it = noise_item();
        it.command        = CMD_TICK;
        it.elapsed_ms     = ms;
        it.error_register = ereg;
        it.fault_flags    = flt;
        it.next_timer_in  = nxt;
        return it;
    endfunction

    // Mostly well-formed frames and ticks with sparse faults, blink steps, some noise
    function automatic item_t rand_item();
        item_t it;
        int    pick;
        it   = noise_item();
        pick = $urandom_range(0, 99);
        if (pick < 34) begin
            it.command = CMD_FRAME;
            if ($urandom_range(0, 6) != 0) begin
                it.frame_length = NMT_FRAME_LEN;
                it.frame_node = ($urandom_range(0, 2) == 0) ? NMT_ALL_NODES
                                                           : {1'b0, node_cfg.node_id};
                case ($urandom_range(0, 6))
                    0, 1, 2: it.frame_command = NMT_START;
                    3:       it.frame_command = NMT_STOP;
                    4:       it.frame_command = NMT_PREOP;
                    5:       it.frame_command = NMT_RESET_NODE;
                    default: it.frame_command = NMT_RESET_COMM;
                endcase
                if ($urandom_range(0, 4) != 0) it.error_register = '0;
            end
        end else if (pick < 70) begin
            it.command = CMD_TICK;
            if (node_cfg.hb_period != 16'd0 && $urandom_range(0, 4) != 0)
                it.elapsed_ms = 16'($urandom_range(0, node_cfg.hb_period));
            if ($urandom_range(0, 3) != 0) it.error_register = '0;
            case ($urandom_range(0, 5))
                0, 1, 2: it.fault_flags = '0;
                3, 4:    it.fault_flags = 7'(1 << $urandom_range(0, 6));
                default: ;
            endcase
            if ($urandom_range(0, 2) == 0) it.next_timer_in = 16'hFFFF;
        end else if (pick < 96) begin
            it.command = CMD_BLINK;
        end else begin
            it.command = CMD_UNUSED;
        end
        return it;
    endfunction

    function automatic cfg_t phase_config(input int p);
        cfg_t c;
        c.node_id       = 7'($urandom_range(1, 127));
        c.hb_period     = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(10, 3000));
        c.first_hb      = 16'($urandom_range(0, 65535));
        c.startup_preop = 1'($urandom_range(0, 1));
        c.err_actions   = 12'($urandom_range(0, 4095));
        c.err_act_en    = 1'($urandom_range(0, 1));
        case (p)
            1: begin
                c.node_id       = 7'd1;
                c.hb_period     = 16'd0;
                c.first_hb      = 16'hFFFF;
                c.startup_preop = 1'b0;
                c.err_actions   = 12'h000;
                c.err_act_en    = 1'b1;
            end
            2: begin
                c.node_id       = 7'd64;
                c.hb_period     = 16'hFFFF;
                c.first_hb      = 16'd0;
                c.startup_preop = 1'b1;
                c.err_actions   = 12'hAAA;
                c.err_act_en    = 1'b1;
            end
            3: c.err_act_en = 1'b0;
            default: ;
        endcase
        return c;
    endfunction

    // Run length guard
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        item_t it;
        cfg_t  c;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        c.node_id       = 7'd127;
        c.hb_period     = 16'd300;
        c.first_hb      = 16'd100;
        c.startup_preop = 1'b1;
        c.err_actions   = 12'hFFF;
        c.err_act_en    = 1'b1;
        load_config(c);

        // broadcast reset request while still initializing, then a frame for another node
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_RESET_NODE, NMT_ALL_NODES, 8'd0));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_STOP, 8'd3, 8'd0));
        // boot-up, then start refused while errors are pending, then accepted
        send_item(proc_tick(16'd0, 8'd0, 7'd0, 16'hFFFF));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_START, 8'd127, 8'hFF));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_START, 8'd127, 8'd0));
        // rejected lengths, foreign node, unknown specifier
        send_item(nmt_frame(4'd8, NMT_STOP, 8'd127, 8'd0));
        send_item(nmt_frame(4'd0, NMT_STOP, NMT_ALL_NODES, 8'd0));
        send_item(nmt_frame(NMT_FRAME_LEN, 8'hFF, 8'hFF, 8'd0));
        send_item(nmt_frame(NMT_FRAME_LEN, 8'd3, 8'd127, 8'd0));
        // heartbeat due, then generic error with every action set to keep
        send_item(proc_tick(16'd150, 8'd0, 7'd0, 16'hFFFF));
        send_item(proc_tick(16'd0, 8'h01, 7'd0, 16'd0));
        repeat (4) begin
            it = noise_item();
            it.command = CMD_BLINK;
            send_item(it);
        end
        it = noise_item();
        it.command = CMD_UNUSED;
        send_item(it);
        // timer wrap with every fault raised
        send_item(proc_tick(16'hFFFF, 8'hFF, 7'h7F, 16'd0));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_STOP, 8'd127, 8'd0));
        send_item(proc_tick(16'd10, 8'd0, 7'h08, 16'hFFFF));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_PREOP, NMT_ALL_NODES, 8'd0));
        send_item(proc_tick(16'd10, 8'd0, 7'h30, 16'hFFFF));
        send_item(proc_tick(16'd5, 8'd0, 7'h40, 16'hFFFF));
        send_item(proc_tick(16'd5, 8'd0, 7'h03, 16'hFFFF));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_RESET_COMM, 8'd127, 8'd0));
        send_item(nmt_frame(NMT_FRAME_LEN, NMT_START, NMT_ALL_NODES, 8'd0));
        send_item(proc_tick(16'd1, 8'hB1, 7'h04, 16'h1234));

        // random traffic, reconfigured between phases once drained
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                wait_drained();
                load_config(phase_config(p));
            end
            repeat (RANDOM_ITEMS / PHASES) send_item(rand_item());
        end
        wait_drained();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
design/nmtsh_pkg.sv
design/nmtsh_cfg.sv
design/nmtsh_blink.sv
design/nmtsh_core.sv
design/nmt_slave_state_heartbeat_led.sv
dv/nmtsh_checker.sv
dv/tb_nmt_slave_state_heartbeat_led.sv
